[design/blit_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blit_pkg
// shared widths, register indexes and pipeline word types of the blit
// rectangle clip front end
// ----------------------------------------------------------------------------
package blit_pkg;

   // surface size registers
   localparam int CFG_W      = 15;
   localparam int MAX_DIM_DEF = 16384;

   // request coordinates and sizes
   localparam int REQ_W = 16;

   // signed working width of the clip chain, room for a few 16-bit steps
   localparam int SW = 19;

   // result corner and offset widths
   localparam int CRD_W = 14;
   localparam int OFF_W = 28;

   // row times surface width, and the linear start position with x added
   localparam int PROD_W = 2 * CFG_W;
   localparam int LIN_W  = PROD_W + 1;

   // configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_WIDTH  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_HEIGHT = 2'd3;

   // captured request word
   typedef struct packed {
      logic [REQ_W-1:0] src_x;
      logic [REQ_W-1:0] src_y;
      logic [REQ_W-1:0] width;
      logic [REQ_W-1:0] height;
      logic [REQ_W-1:0] dst_x;
      logic [REQ_W-1:0] dst_y;
      logic             same;
   } req_type;

   // clipped rectangle word
   typedef struct packed {
      logic             empty;
      logic             same;
      logic [CFG_W-1:0] src_x;
      logic [CFG_W-1:0] src_y;
      logic [CFG_W-1:0] dst_x;
      logic [CFG_W-1:0] dst_y;
      logic [CFG_W-1:0] width;
      logic [CFG_W-1:0] height;
   } clip_type;

   // row products word
   typedef struct packed {
      logic              empty;
      logic              same;
      logic [CFG_W-1:0]  src_x;
      logic [CFG_W-1:0]  src_y;
      logic [CFG_W-1:0]  dst_x;
      logic [CFG_W-1:0]  dst_y;
      logic [CFG_W-1:0]  width;
      logic [CFG_W-1:0]  height;
      logic [PROD_W-1:0] src_top;
      logic [PROD_W-1:0] dst_top;
      logic [PROD_W-1:0] src_bot;
      logic [PROD_W-1:0] dst_bot;
   } prod_type;

   // result word
   typedef struct packed {
      logic             empty;
      logic [CRD_W-1:0] src_x;
      logic [CRD_W-1:0] src_y;
      logic [CRD_W-1:0] dst_x;
      logic [CRD_W-1:0] dst_y;
      logic [CFG_W-1:0] width;
      logic [CFG_W-1:0] height;
      logic             reverse;
      logic [OFF_W-1:0] src_off;
      logic [OFF_W-1:0] dst_off;
   } rsp_type;

endpackage

[design/blit_rectangle_clip_and_direction.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blit_rectangle_clip_and_direction
// clips a blit request against source and destination surfaces and picks
// the copy direction for overlapping copies within one surface
// ----------------------------------------------------------------------------
// Each request word (source corner, size, destination corner, same-surface
// flag) is clipped against the source surface (right, left, bottom, top) and
// then the destination surface in that order; a left or top clip on one side
// shifts the corner on the other side by the same amount. When nothing is
// left the result word has rsp_empty_res set and every other field zero.
// For a copy within one surface the linear start positions y * width + x
// are compared: if the source starts after the destination the copy runs
// forward, otherwise rsp_reverse_order is set (rows bottom-up, each row end
// first). The offsets give the start of the first copied row on each side.
// The block takes one word per cycle unless all stages are full behind a
// stalled result; it is a four-deep pipeline (input capture, clip, row
// multiplies, compare and offset add) where any empty stage closes up under
// a stalled output. Surface sizes must be written through the csr port only
// while the block is idle, which the block does not enforce; a written value
// above MAX_DIM is saturated to MAX_DIM. csr_ready is always high.
// ----------------------------------------------------------------------------
module blit_rectangle_clip_and_direction
   import blit_pkg::*;
#(
   parameter int MAX_DIM = MAX_DIM_DEF
) (
   input  logic                 clock,
   input  logic                 reset,

   // configuration write channel
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata,

   // request channel
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [REQ_W-1:0]     req_src_x,
   input  logic [REQ_W-1:0]     req_src_y,
   input  logic [REQ_W-1:0]     req_width,
   input  logic [REQ_W-1:0]     req_height,
   input  logic [REQ_W-1:0]     req_dst_x,
   input  logic [REQ_W-1:0]     req_dst_y,
   input  logic                 req_same_surface,

   // result channel
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_empty_res,
   output logic [CRD_W-1:0]     rsp_out_src_x,
   output logic [CRD_W-1:0]     rsp_out_src_y,
   output logic [CRD_W-1:0]     rsp_out_dst_x,
   output logic [CRD_W-1:0]     rsp_out_dst_y,
   output logic [CFG_W-1:0]     rsp_out_width,
   output logic [CFG_W-1:0]     rsp_out_height,
   output logic                 rsp_reverse_order,
   output logic [OFF_W-1:0]     rsp_src_first_offset,
   output logic [OFF_W-1:0]     rsp_dst_first_offset
);

   // -------------------------------------------------------------------------
   // surface size registers
   // -------------------------------------------------------------------------
   logic [CFG_W-1:0] src_w_ff, src_h_ff, dst_w_ff, dst_h_ff;
   logic [CFG_W-1:0] csr_sat;

   assign csr_ready = 1'b1;

   // clamp to the largest surface dimension
   always_comb begin
      csr_sat = csr_wdata;
      if ({{(32-CFG_W){1'b0}}, csr_wdata} > 32'(MAX_DIM)) begin
         csr_sat = CFG_W'(MAX_DIM);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_ff <= '0;
         src_h_ff <= '0;
         dst_w_ff <= '0;
         dst_h_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SOURCE_WIDTH:  src_w_ff <= csr_sat;
            CSR_SOURCE_HEIGHT: src_h_ff <= csr_sat;
            CSR_TARGET_WIDTH:  dst_w_ff <= csr_sat;
            CSR_TARGET_HEIGHT: dst_h_ff <= csr_sat;
            default: ;
         endcase
      end
   end

   // -------------------------------------------------------------------------
   // pipeline flow control: a stage loads when it is empty or moves on
   // -------------------------------------------------------------------------
   logic     v0_ff, v1_ff, v2_ff, rsp_v_ff;
   logic     adv_out, adv2, adv1;
   req_type  s0_ff, s0_in;
   clip_type s1_ff, s1_in;
   prod_type s2_ff, s2_in;
   rsp_type  rsp_ff, rsp_in;

   assign adv_out   = !rsp_v_ff || rsp_ready;
   assign adv2      = !v2_ff || adv_out;
   assign adv1      = !v1_ff || adv2;
   assign req_ready = !v0_ff || adv1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff    <= 1'b0;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else begin
         if (req_ready) v0_ff    <= req_valid;
         if (adv1)      v1_ff    <= v0_ff;
         if (adv2)      v2_ff    <= v1_ff;
         if (adv_out)   rsp_v_ff <= v2_ff;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_ready) s0_ff  <= s0_in;
      if (adv1)      s1_ff  <= s1_in;
      if (adv2)      s2_ff  <= s2_in;
      if (adv_out)   rsp_ff <= rsp_in;
   end

   // -------------------------------------------------------------------------
   // stage 0: capture the request word
   // -------------------------------------------------------------------------
   always_comb begin
      s0_in.src_x  = req_src_x;
      s0_in.src_y  = req_src_y;
      s0_in.width  = req_width;
      s0_in.height = req_height;
      s0_in.dst_x  = req_dst_x;
      s0_in.dst_y  = req_dst_y;
      s0_in.same   = req_same_surface;
   end

   // -------------------------------------------------------------------------
   // stage 1: clip chain
   // horizontal and vertical chains are independent, four steps each;
   // once empty is set the later values no longer matter
   // -------------------------------------------------------------------------
   logic signed [SW-1:0] sx, sy, dx, dy, cw, ch;
   logic signed [SW-1:0] sw_s, sh_s, tw_s, th_s;
   logic                 clip_empty;

   always_comb begin
      sw_s = SW'($signed({1'b0, src_w_ff}));
      sh_s = SW'($signed({1'b0, src_h_ff}));
      tw_s = SW'($signed({1'b0, dst_w_ff}));
      th_s = SW'($signed({1'b0, dst_h_ff}));

      sx = SW'($signed(s0_ff.src_x));
      sy = SW'($signed(s0_ff.src_y));
      dx = SW'($signed(s0_ff.dst_x));
      dy = SW'($signed(s0_ff.dst_y));
      cw = SW'($signed(s0_ff.width));
      ch = SW'($signed(s0_ff.height));

      clip_empty = (cw <= 0) || (ch <= 0);

      // source right and left edges
      if (sx + cw > sw_s) cw = sw_s - sx;
      clip_empty = clip_empty || (cw <= 0);
      if (sx < 0) begin
         dx = dx - sx;
         cw = cw + sx;
         sx = '0;
      end
      clip_empty = clip_empty || (cw <= 0);

      // source bottom and top edges
      if (sy + ch > sh_s) ch = sh_s - sy;
      clip_empty = clip_empty || (ch <= 0);
      if (sy < 0) begin
         dy = dy - sy;
         ch = ch + sy;
         sy = '0;
      end
      clip_empty = clip_empty || (ch <= 0);

      // destination right and left edges
      if (dx + cw > tw_s) cw = tw_s - dx;
      clip_empty = clip_empty || (cw <= 0);
      if (dx < 0) begin
         sx = sx - dx;
         cw = cw + dx;
         dx = '0;
      end
      clip_empty = clip_empty || (cw <= 0);

      // destination bottom and top edges
      if (dy + ch > th_s) ch = th_s - dy;
      clip_empty = clip_empty || (ch <= 0);
      if (dy < 0) begin
         sy = sy - dy;
         ch = ch + dy;
         dy = '0;
      end
      clip_empty = clip_empty || (ch <= 0);

      // surviving corners lie below the surface sizes, sizes do not exceed them
      s1_in.empty  = clip_empty;
      s1_in.same   = s0_ff.same;
      s1_in.src_x  = sx[CFG_W-1:0];
      s1_in.src_y  = sy[CFG_W-1:0];
      s1_in.dst_x  = dx[CFG_W-1:0];
      s1_in.dst_y  = dy[CFG_W-1:0];
      s1_in.width  = cw[CFG_W-1:0];
      s1_in.height = ch[CFG_W-1:0];
   end

   // -------------------------------------------------------------------------
   // stage 2: row start products for top and bottom rows on both sides
   // -------------------------------------------------------------------------
   logic [CFG_W-1:0] src_bot_row, dst_bot_row;

   always_comb begin
      src_bot_row = s1_ff.src_y + s1_ff.height - CFG_W'(1);
      dst_bot_row = s1_ff.dst_y + s1_ff.height - CFG_W'(1);

      s2_in.empty   = s1_ff.empty;
      s2_in.same    = s1_ff.same;
      s2_in.src_x   = s1_ff.src_x;
      s2_in.src_y   = s1_ff.src_y;
      s2_in.dst_x   = s1_ff.dst_x;
      s2_in.dst_y   = s1_ff.dst_y;
      s2_in.width   = s1_ff.width;
      s2_in.height  = s1_ff.height;
      s2_in.src_top = PROD_W'(s1_ff.src_y) * PROD_W'(src_w_ff);
      s2_in.dst_top = PROD_W'(s1_ff.dst_y) * PROD_W'(dst_w_ff);
      s2_in.src_bot = PROD_W'(src_bot_row) * PROD_W'(src_w_ff);
      s2_in.dst_bot = PROD_W'(dst_bot_row) * PROD_W'(dst_w_ff);
   end

   // -------------------------------------------------------------------------
   // stage 3: direction and first row offsets
   // -------------------------------------------------------------------------
   logic [LIN_W-1:0] lin_src, lin_dst, off_src, off_dst;
   logic             rev;

   always_comb begin
      lin_src = LIN_W'(s2_ff.src_top) + LIN_W'(s2_ff.src_x);
      lin_dst = LIN_W'(s2_ff.dst_top) + LIN_W'(s2_ff.dst_x);

      // source not strictly after destination: copy bottom-up, end first
      rev = s2_ff.same && !(lin_src > lin_dst);

      off_src = LIN_W'(rev ? s2_ff.src_bot : s2_ff.src_top) + LIN_W'(s2_ff.src_x);
      off_dst = LIN_W'(rev ? s2_ff.dst_bot : s2_ff.dst_top) + LIN_W'(s2_ff.dst_x);

      rsp_in = '0;
      rsp_in.empty = 1'b1;
      if (!s2_ff.empty) begin
         rsp_in.empty   = 1'b0;
         rsp_in.src_x   = s2_ff.src_x[CRD_W-1:0];
         rsp_in.src_y   = s2_ff.src_y[CRD_W-1:0];
         rsp_in.dst_x   = s2_ff.dst_x[CRD_W-1:0];
         rsp_in.dst_y   = s2_ff.dst_y[CRD_W-1:0];
         rsp_in.width   = s2_ff.width;
         rsp_in.height  = s2_ff.height;
         rsp_in.reverse = rev;
         rsp_in.src_off = off_src[OFF_W-1:0];
         rsp_in.dst_off = off_dst[OFF_W-1:0];
      end
   end

   // -------------------------------------------------------------------------
   // result ports
   // -------------------------------------------------------------------------
   assign rsp_valid            = rsp_v_ff;
   assign rsp_empty_res        = rsp_ff.empty;
   assign rsp_out_src_x        = rsp_ff.src_x;
   assign rsp_out_src_y        = rsp_ff.src_y;
   assign rsp_out_dst_x        = rsp_ff.dst_x;
   assign rsp_out_dst_y        = rsp_ff.dst_y;
   assign rsp_out_width        = rsp_ff.width;
   assign rsp_out_height       = rsp_ff.height;
   assign rsp_reverse_order    = rsp_ff.reverse;
   assign rsp_src_first_offset = rsp_ff.src_off;
   assign rsp_dst_first_offset = rsp_ff.dst_off;

   // -------------------------------------------------------------------------
   // assertions
   // -------------------------------------------------------------------------
`ifndef SYNTHESIS
   // an empty result carries zero size, direction and offsets
   a_empty_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_empty_res) |->
         (rsp_out_width == '0 && rsp_out_height == '0 && !rsp_reverse_order &&
          rsp_src_first_offset == '0 && rsp_dst_first_offset == '0))
      else $error("empty result with nonzero fields");

   // a non-empty result has a real size
   a_size_nonzero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_empty_res) |-> (rsp_out_width != '0 && rsp_out_height != '0))
      else $error("non-empty result with zero size");

   // clipped source corner lies inside the source surface
   a_src_inside : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_empty_res) |->
         ({1'b0, rsp_out_src_x} < src_w_ff && {1'b0, rsp_out_src_y} < src_h_ff))
      else $error("clipped source corner outside surface");

   // input stalls only when every stage holds a word behind a stalled result
   a_stall_full : assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready && v0_ff && v1_ff && v2_ff))
      else $error("request stalled with room in the pipeline");
`endif

endmodule

[test/blit_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blit_checker
// Watches the csr, request and result channels of the blit clip front end.
// Each accepted request word is clipped by a local model of the block. The
// predicted result is queued, and each accepted result word is compared with
// the oldest queued prediction, field by field.
// ----------------------------------------------------------------------------
module blit_checker
   import blit_pkg::*;
#(
   parameter int SAT_DIM = MAX_DIM_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  logic [REQ_W-1:0]     req_src_x,
   input  logic [REQ_W-1:0]     req_src_y,
   input  logic [REQ_W-1:0]     req_width,
   input  logic [REQ_W-1:0]     req_height,
   input  logic [REQ_W-1:0]     req_dst_x,
   input  logic [REQ_W-1:0]     req_dst_y,
   input  logic                 req_same_surface,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic                 rsp_empty_res,
   input  logic [CRD_W-1:0]     rsp_out_src_x,
   input  logic [CRD_W-1:0]     rsp_out_src_y,
   input  logic [CRD_W-1:0]     rsp_out_dst_x,
   input  logic [CRD_W-1:0]     rsp_out_dst_y,
   input  logic [CFG_W-1:0]     rsp_out_width,
   input  logic [CFG_W-1:0]     rsp_out_height,
   input  logic                 rsp_reverse_order,
   input  logic [OFF_W-1:0]     rsp_src_first_offset,
   input  logic [OFF_W-1:0]     rsp_dst_first_offset,
   output int                   mismatch_total,
   output int                   owed_count
);

   // surface sizes as the block should hold them
   longint src_w, src_h, dst_w, dst_h;

   rsp_type clipped_q[$];
   rsp_type want, got;
   req_type seen;
   longint  dim;
   int      errs;
   int      words_checked;

   function automatic rsp_type clip_blit(input req_type r);
      longint  sx, sy, w, h, dx, dy, lin_s, lin_d, row_s, row_d;
      bit      gone, rev;
      rsp_type res;
      sx  = longint'($signed(r.src_x));
      sy  = longint'($signed(r.src_y));
      w   = longint'($signed(r.width));
      h   = longint'($signed(r.height));
      dx  = longint'($signed(r.dst_x));
      dy  = longint'($signed(r.dst_y));
      res = '0;

      // source right, then left; a left clip moves the destination corner
      gone = (w <= 0);
      if (!gone) begin
         if (sx + w > src_w) w = src_w - sx;
         gone = (w <= 0);
      end
      if (!gone) begin
         if (sx < 0) begin dx -= sx; w += sx; sx = 0; end
         gone = (w <= 0);
      end
      // source bottom, then top
      if (!gone) gone = (h <= 0);
      if (!gone) begin
         if (sy + h > src_h) h = src_h - sy;
         gone = (h <= 0);
      end
      if (!gone) begin
         if (sy < 0) begin dy -= sy; h += sy; sy = 0; end
         gone = (h <= 0);
      end
      // destination right, left, bottom, top
      if (!gone) begin
         if (dx + w > dst_w) w = dst_w - dx;
         gone = (w <= 0);
      end
      if (!gone) begin
         if (dx < 0) begin sx -= dx; w += dx; dx = 0; end
         gone = (w <= 0);
      end
      if (!gone) begin
         if (dy + h > dst_h) h = dst_h - dy;
         gone = (h <= 0);
      end
      if (!gone) begin
         if (dy < 0) begin sy -= dy; h += dy; dy = 0; end
         gone = (h <= 0);
      end

      if (gone) begin
         res.empty = 1'b1;
         return res;
      end

      // equal start positions also run in reverse
      rev = 1'b0;
      if (r.same) begin
         lin_s = sy * src_w + sx;
         lin_d = dy * dst_w + dx;
         rev   = !(lin_s > lin_d);
      end
      row_s = rev ? sy + h - 1 : sy;
      row_d = rev ? dy + h - 1 : dy;

      res.src_x   = CRD_W'(sx);
      res.src_y   = CRD_W'(sy);
      res.dst_x   = CRD_W'(dx);
      res.dst_y   = CRD_W'(dy);
      res.width   = CFG_W'(w);
      res.height  = CFG_W'(h);
      res.reverse = rev;
      res.src_off = OFF_W'(row_s * src_w + sx);
      res.dst_off = OFF_W'(row_d * dst_w + dx);
      return res;
   endfunction

   task automatic note_field(input string name, input longint exp_val, input longint act_val);
      if (exp_val != act_val) begin
         if (errs < 10)
            $display("result word %0d: %s expected 0x%0h got 0x%0h",
                     words_checked, name, exp_val, act_val);
         errs++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         src_w = 0;
         src_h = 0;
         dst_w = 0;
         dst_h = 0;
         clipped_q.delete();
         errs = 0;
         words_checked = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            dim = longint'(csr_wdata);
            if (dim > longint'(SAT_DIM)) dim = longint'(SAT_DIM);
            case (csr_index)
               CSR_SOURCE_WIDTH:  src_w = dim;
               CSR_SOURCE_HEIGHT: src_h = dim;
               CSR_TARGET_WIDTH:  dst_w = dim;
               CSR_TARGET_HEIGHT: dst_h = dim;
               default: ;
            endcase
         end

         if (rsp_valid && rsp_ready) begin
            got.empty   = rsp_empty_res;
            got.src_x   = rsp_out_src_x;
            got.src_y   = rsp_out_src_y;
            got.dst_x   = rsp_out_dst_x;
            got.dst_y   = rsp_out_dst_y;
            got.width   = rsp_out_width;
            got.height  = rsp_out_height;
            got.reverse = rsp_reverse_order;
            got.src_off = rsp_src_first_offset;
            got.dst_off = rsp_dst_first_offset;
            if (clipped_q.size() == 0) begin
               if (errs < 10)
                  $display("result word %0d arrived with nothing outstanding", words_checked);
               errs++;
            end else begin
               want = clipped_q.pop_front();
               note_field("empty_res", longint'(want.empty), longint'(got.empty));
               note_field("out_src_x", longint'(want.src_x), longint'(got.src_x));
               note_field("out_src_y", longint'(want.src_y), longint'(got.src_y));
               note_field("out_dst_x", longint'(want.dst_x), longint'(got.dst_x));
               note_field("out_dst_y", longint'(want.dst_y), longint'(got.dst_y));
               note_field("out_width", longint'(want.width), longint'(got.width));
               note_field("out_height", longint'(want.height), longint'(got.height));
               note_field("reverse_order", longint'(want.reverse), longint'(got.reverse));
               note_field("src_first_offset", longint'(want.src_off), longint'(got.src_off));
               note_field("dst_first_offset", longint'(want.dst_off), longint'(got.dst_off));
            end
            words_checked++;
         end

         if (req_valid && req_ready) begin
            seen.src_x  = req_src_x;
            seen.src_y  = req_src_y;
            seen.width  = req_width;
            seen.height = req_height;
            seen.dst_x  = req_dst_x;
            seen.dst_y  = req_dst_y;
            seen.same   = req_same_surface;
            clipped_q.push_back(clip_blit(seen));
         end
      end
      mismatch_total <= errs;
      owed_count     <= clipped_q.size();
   end

endmodule

[test/blit_rectangle_clip_and_direction_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blit_rectangle_clip_and_direction_tb
// Drives blit requests through the clip front end under several surface size
// settings: a directed set of corner cases first, then random requests shaped
// to land near the surface edges. Sender and receiver both idle at random.
// Checking is done by blit_checker; this module makes stimulus and verdict.
// ----------------------------------------------------------------------------
module blit_rectangle_clip_and_direction_tb;
   import blit_pkg::*;

   localparam int WORDS_PER_PHASE = 175;
   localparam int QUIET_LIMIT     = 5000;

   logic                 clock;
   logic                 reset;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_wdata;
   logic                 req_valid;
   logic                 req_ready;
   logic [REQ_W-1:0]     req_src_x;
   logic [REQ_W-1:0]     req_src_y;
   logic [REQ_W-1:0]     req_width;
   logic [REQ_W-1:0]     req_height;
   logic [REQ_W-1:0]     req_dst_x;
   logic [REQ_W-1:0]     req_dst_y;
   logic                 req_same_surface;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic                 rsp_empty_res;
   logic [CRD_W-1:0]     rsp_out_src_x;
   logic [CRD_W-1:0]     rsp_out_src_y;
   logic [CRD_W-1:0]     rsp_out_dst_x;
   logic [CRD_W-1:0]     rsp_out_dst_y;
   logic [CFG_W-1:0]     rsp_out_width;
   logic [CFG_W-1:0]     rsp_out_height;
   logic                 rsp_reverse_order;
   logic [OFF_W-1:0]     rsp_src_first_offset;
   logic [OFF_W-1:0]     rsp_dst_first_offset;
   int                   mismatch_total;
   int                   owed_count;

   // surface sizes as last written, saturated, used only to aim random words
   int surf_dim[4];
   // words left in the current burst before the sender takes a gap
   int burst_left;
   int quiet_cycles;

   blit_rectangle_clip_and_direction dut (.*);

   blit_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // watchdog: nothing accepted on any channel for too long ends the run
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("blit_rectangle_clip_and_direction verification failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // receiver: stall pattern switches mode every so often
   // mode 0 never stalls, 1 is a coin toss, 2 takes one word in four,
   // 3 stalls rarely
   // ---------------------------------------------------------------------
   initial begin
      int stall_mode;
      int mode_left;
      stall_mode = 0;
      mode_left  = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(16, 200);
         end
         mode_left--;
         case (stall_mode)
            0:       rsp_ready <= 1'b1;
            1:       rsp_ready <= ($urandom_range(0, 1) == 1);
            2:       rsp_ready <= (mode_left % 4 == 0);
            default: rsp_ready <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // request word sender, bursts with random gaps between them
   // ---------------------------------------------------------------------
   task automatic send_word(input req_type w);
      int gap;
      if (burst_left == 0) begin
         // now and then a long stretch with no gaps at all
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                  : $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid        <= 1'b1;
      req_src_x        <= w.src_x;
      req_src_y        <= w.src_y;
      req_width        <= w.width;
      req_height       <= w.height;
      req_dst_x        <= w.dst_x;
      req_dst_y        <= w.dst_y;
      req_same_surface <= w.same;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_rect(input int sx, input int sy, input int w, input int h,
                            input int dx, input int dy, input bit same);
      req_type r;
      r.src_x  = REQ_W'(sx);
      r.src_y  = REQ_W'(sy);
      r.width  = REQ_W'(w);
      r.height = REQ_W'(h);
      r.dst_x  = REQ_W'(dx);
      r.dst_y  = REQ_W'(dy);
      r.same   = same;
      send_word(r);
   endtask

   // wait until every result is back, then write all four surface sizes
   task automatic reconfigure(input int s_w, input int s_h, input int t_w, input int t_h);
      int vals[4];
      vals = '{s_w, s_h, t_w, t_h};
      req_valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (owed_count != 0);
      // the block is drained; let its pipeline settle before writing
      repeat (4) @(posedge clock);
      for (int i = 0; i < 4; i++) begin
         csr_valid <= 1'b1;
         csr_index <= (i == 0) ? CSR_SOURCE_WIDTH :
                      (i == 1) ? CSR_SOURCE_HEIGHT :
                      (i == 2) ? CSR_TARGET_WIDTH : CSR_TARGET_HEIGHT;
         csr_wdata <= CFG_W'(vals[i]);
         do @(posedge clock); while (!csr_ready);
         surf_dim[i] = (vals[i] > MAX_DIM_DEF) ? MAX_DIM_DEF : vals[i];
      end
      csr_valid <= 1'b0;
   endtask

   // corner coordinate near either edge of a surface, off its top left, or anywhere within
   function automatic logic [REQ_W-1:0] near_edge(input int span);
      int v;
      case ($urandom_range(0, 4))
         0:       v = int'($urandom_range(0, 16)) - 8;
         1:       v = span + int'($urandom_range(0, 16)) - 12;
         2:       v = -int'($urandom_range(0, span / 2 + 1));
         default: v = int'($urandom_range(0, span));
      endcase
      return REQ_W'(v);
   endfunction

   // rectangle extent: tiny, around the surface size, or anywhere within
   function automatic logic [REQ_W-1:0] extent(input int span);
      int v;
      case ($urandom_range(0, 3))
         0:       v = $urandom_range(1, 8);
         1:       v = span + int'($urandom_range(0, 32)) - 16;
         default: v = $urandom_range(1, span + 1);
      endcase
      return REQ_W'(v);
   endfunction

   function automatic req_type random_req();
      int      pick;
      req_type r;
      pick   = $urandom_range(0, 99);
      r.same = 1'($urandom_range(0, 1));
      if (pick < 25) begin
         // raw noise over the full 16-bit fields
         r.src_x  = REQ_W'($urandom);
         r.src_y  = REQ_W'($urandom);
         r.width  = REQ_W'($urandom);
         r.height = REQ_W'($urandom);
         r.dst_x  = REQ_W'($urandom);
         r.dst_y  = REQ_W'($urandom);
      end else begin
         r.src_x  = near_edge(surf_dim[0]);
         r.src_y  = near_edge(surf_dim[1]);
         r.width  = extent(surf_dim[0]);
         r.height = extent(surf_dim[1]);
         if (r.same && $urandom_range(0, 1) == 1) begin
            // overlapping copy within one surface, either direction
            r.dst_x = REQ_W'(int'($signed(r.src_x)) + int'($urandom_range(0, 40)) - 20);
            r.dst_y = REQ_W'(int'($signed(r.src_y)) + int'($urandom_range(0, 6)) - 3);
         end else begin
            r.dst_x = near_edge(surf_dim[2]);
            r.dst_y = near_edge(surf_dim[3]);
         end
         // a few degenerate sizes
         if (pick >= 92) begin
            if ($urandom_range(0, 1) == 1)
               r.width = REQ_W'(-int'($urandom_range(0, 40)));
            else
               r.height = REQ_W'(-int'($urandom_range(0, 40)));
         end
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // main stimulus
   // ---------------------------------------------------------------------
   initial begin
      csr_valid        <= 1'b0;
      csr_index        <= CSR_SOURCE_WIDTH;
      csr_wdata        <= '0;
      req_valid        <= 1'b0;
      req_src_x        <= '0;
      req_src_y        <= '0;
      req_width        <= '0;
      req_height       <= '0;
      req_dst_x        <= '0;
      req_dst_y        <= '0;
      req_same_surface <= 1'b0;
      reset            <= 1'b1;
      surf_dim   = '{0, 0, 0, 0};
      burst_left = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // surfaces of size zero straight out of reset, always empty
      send_rect(0, 0, 10, 10, 0, 0, 0);
      send_rect(5, 5, 1, 1, 5, 5, 1);

      reconfigure(100, 80, 120, 60);
      send_rect(10, 20, 30, 15, 40, 5, 0);                      // no clipping
      send_rect(10, 10, 0, 5, 10, 10, 0);                       // zero width
      send_rect(10, 10, 5, -3, 10, 10, 0);                      // negative height
      send_rect(0, 0, -32768, 32767, 0, 0, 0);                  // most negative width
      send_rect(90, 10, 50, 10, 0, 0, 0);                       // source right edge
      send_rect(-5, 10, 20, 10, 30, 30, 0);                     // source left, dst shifts
      send_rect(-50, 10, 20, 10, 0, 0, 0);                      // entirely left of source
      send_rect(0, -7, 10, 100, 0, 0, 0);                       // source top and bottom
      send_rect(0, 0, 50, 10, 100, 0, 0);                       // destination right edge
      send_rect(10, 10, 20, 10, -8, -4, 0);                     // destination left and top
      send_rect(0, 0, 10, 50, 0, 40, 0);                        // destination bottom edge
      send_rect(20, 10, 30, 5, 10, 10, 1);                      // same surface, reverse (wider target)
      send_rect(10, 10, 30, 5, 20, 10, 1);                      // same surface, reverse
      send_rect(10, 10, 5, 5, 10, 10, 1);                       // equal corners go reverse
      send_rect(32767, 32767, 32767, 32767, -32768, -32768, 0); // field extremes
      send_rect(-32768, -32768, 32767, 32767, 32767, 32767, 1);
      send_rect(-1, -1, -1, -1, -1, -1, 1);                     // all ones
      send_rect(0, 0, 100, 80, 0, 0, 1);                        // whole surface
      send_rect(99, 79, 1, 1, 119, 59, 0);                      // far corner pixel

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            // source width above the limit saturates
            0: reconfigure(32767, 16384, 16384, 16384);
            1: reconfigure(1, 1, 1, 1);
            2: reconfigure($urandom_range(0, 300), $urandom_range(0, 300),
                           $urandom_range(0, 300), $urandom_range(0, 300));
            // saturating source sizes, a narrow target and an empty one
            3: reconfigure(20000, 16385, 5, 0);
            4: reconfigure($urandom_range(0, 32767), $urandom_range(0, 32767),
                           $urandom_range(0, 32767), $urandom_range(0, 32767));
            default: reconfigure(64, 64, 64, 64);
         endcase
         if (phase == 0) begin
            // largest surfaces: full size copy and offsets at their top
            send_rect(0, 0, 16384, 16384, 0, 0, 1);
            send_rect(16383, 16383, 1, 1, 0, 0, 1);
            send_rect(0, 0, 1, 1, 16383, 16383, 1);
         end
         for (int n = 0; n < WORDS_PER_PHASE; n++)
            send_word(random_req());
      end

      req_valid <= 1'b0;
      do @(posedge clock); while (owed_count != 0);
      repeat (8) @(posedge clock);
      if (mismatch_total == 0 && owed_count == 0)
         $display("blit_rectangle_clip_and_direction verification clean");
      else
         $display("blit_rectangle_clip_and_direction verification failed");
      $finish;
   end

endmodule

[sim.f]
design/blit_pkg.sv
design/blit_rectangle_clip_and_direction.sv
test/blit_checker.sv
test/blit_rectangle_clip_and_direction_tb.sv
